>>> design/nonrestoring_signed_divider_top_assert.svh
// Assertion macros shared by the divider modules.
// Each macro expands to one labeled concurrent assertion, clocked on the
// rising edge and disabled while reset is held low.
`ifndef NONRESTORING_SIGNED_DIVIDER_TOP_ASSERT_SVH
`define NONRESTORING_SIGNED_DIVIDER_TOP_ASSERT_SVH

// The property must hold at every clock edge out of reset.
`define NRD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("nrd assertion failed");

// The condition must never be true out of reset.
`define NRD_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("nrd forbidden condition seen");

`endif

>>> design/nrd_pkg.sv
// ----------------------------------------------------------------------------
// nrd_pkg
// Shared types and constants of the signed non-restoring divider.
// ----------------------------------------------------------------------------
package nrd_pkg;

    // Width of the operand and result fields on the channels.
    localparam int unsigned FIELD_W = 16;

    typedef logic signed [FIELD_W-1:0] t_operand;
    typedef logic        [FIELD_W-1:0] t_mag;

    // Sign and exception flags that ride along with each division.
    typedef struct packed {
        logic qneg;
        logic rneg;
        logic dbz;
    } t_flags;

endpackage

>>> design/nrd_in_if.sv
// ----------------------------------------------------------------------------
// nrd_in_if
// Operand channel: one signed dividend and divisor pair per transaction.
// ----------------------------------------------------------------------------
interface nrd_in_if;
    logic              valid;
    logic              ready;
    nrd_pkg::t_operand dividend;
    nrd_pkg::t_operand divisor;

    modport source (output valid, output dividend, output divisor, input ready);
    modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

>>> design/nrd_out_if.sv
// ----------------------------------------------------------------------------
// nrd_out_if
// Result channel: quotient and remainder magnitudes with sign flags.
// ----------------------------------------------------------------------------
interface nrd_out_if;
    logic          valid;
    logic          ready;
    nrd_pkg::t_mag quotient_magnitude;
    logic          quotient_negative;
    nrd_pkg::t_mag remainder_magnitude;
    logic          remainder_negative;
    logic          divide_by_zero;

    modport source (
        output valid, output quotient_magnitude, output quotient_negative,
        output remainder_magnitude, output remainder_negative,
        output divide_by_zero, input ready
    );
    modport sink (
        input valid, input quotient_magnitude, input quotient_negative,
        input remainder_magnitude, input remainder_negative,
        input divide_by_zero, output ready
    );
endinterface

>>> design/nrd_cell.sv
// ----------------------------------------------------------------------------
// nrd_cell
// One non-restoring step: shift the accumulator and quotient, add or subtract
// the divisor and register the new quotient bit, with its own valid bit.
// ----------------------------------------------------------------------------
`include "nonrestoring_signed_divider_top_assert.svh"

module nrd_cell #(
    parameter int unsigned WIDTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [WIDTH:0]     i_acc,
    input  logic [WIDTH-1:0]   i_q,
    input  logic [WIDTH-1:0]   i_m,
    input  nrd_pkg::t_flags    i_flags,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [WIDTH:0]     o_acc,
    output logic [WIDTH-1:0]   o_q,
    output logic [WIDTH-1:0]   o_m,
    output nrd_pkg::t_flags    o_flags
);

    logic               r_valid;
    logic [WIDTH:0]     r_acc;
    logic [WIDTH-1:0]   r_q;
    logic [WIDTH-1:0]   r_m;
    nrd_pkg::t_flags    r_flags;

    logic [WIDTH:0]     n_acc;
    logic [WIDTH-1:0]   n_q;
    logic [WIDTH:0]     w_shift;
    logic               w_load;

    // The sign of the accumulator before the shift picks add or subtract.
    always_comb begin
        w_shift = {i_acc[WIDTH-1:0], i_q[WIDTH-1]};
        if (i_acc[WIDTH]) begin
            n_acc = w_shift + {1'b0, i_m};
        end else begin
            n_acc = w_shift - {1'b0, i_m};
        end
        n_q = {i_q[WIDTH-2:0], ~n_acc[WIDTH]};
    end

    assign o_ready = !r_valid || i_ready;
    assign w_load  = o_ready && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_acc   <= n_acc;
            r_q     <= n_q;
            r_m     <= i_m;
            r_flags <= i_flags;
        end
    end

    assign o_valid = r_valid;
    assign o_acc   = r_acc;
    assign o_q     = r_q;
    assign o_m     = r_m;
    assign o_flags = r_flags;

    // For a nonzero divisor the partial remainder lies in [-m, m).
    `NRD_ASSERT(a_acc_range, i_clk, i_rst_n, (r_valid && !r_flags.dbz) |-> (($signed(r_acc) < $signed({1'b0, r_m})) && ($signed(r_acc) >= -$signed({1'b0, r_m}))))
    `NRD_ASSERT(a_dbz_matches_m, i_clk, i_rst_n, r_valid |-> (r_flags.dbz == (r_m == '0)))
    `NRD_ASSERT(a_stall_holds, i_clk, i_rst_n, (r_valid && !i_ready) |=> (r_valid && $stable(r_acc) && $stable(r_q)))

endmodule

>>> design/nrd_final.sv
// ----------------------------------------------------------------------------
// nrd_final
// Remainder correction and result register that drives the result channel.
// ----------------------------------------------------------------------------
`include "nonrestoring_signed_divider_top_assert.svh"

module nrd_final #(
    parameter int unsigned WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH:0]   i_acc,
    input  logic [WIDTH-1:0] i_q,
    input  logic [WIDTH-1:0] i_m,
    input  nrd_pkg::t_flags  i_flags,
    nrd_out_if.source        o_out
);

    logic            r_valid;
    nrd_pkg::t_mag   r_qmag;
    nrd_pkg::t_mag   r_rmag;
    logic            r_qneg;
    logic            r_rneg;
    logic            r_dbz;

    logic [WIDTH:0]  w_rem;
    logic            w_load;

    // A negative remainder gets the divisor added back once.
    assign w_rem = i_acc[WIDTH] ? (i_acc + {1'b0, i_m}) : i_acc;

    assign o_ready = !r_valid || o_out.ready;
    assign w_load  = o_ready && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (i_flags.dbz) begin
                r_qmag <= '0;
                r_rmag <= '0;
                r_qneg <= 1'b0;
                r_rneg <= 1'b0;
            end else begin
                r_qmag <= nrd_pkg::t_mag'(i_q);
                r_rmag <= nrd_pkg::t_mag'(w_rem);
                r_qneg <= i_flags.qneg;
                r_rneg <= i_flags.rneg;
            end
            r_dbz <= i_flags.dbz;
        end
    end

    assign o_out.valid               = r_valid;
    assign o_out.quotient_magnitude  = r_qmag;
    assign o_out.quotient_negative   = r_qneg;
    assign o_out.remainder_magnitude = r_rmag;
    assign o_out.remainder_negative  = r_rneg;
    assign o_out.divide_by_zero      = r_dbz;

    `NRD_ASSERT(a_rem_below_divisor, i_clk, i_rst_n, (w_load && !i_flags.dbz) |-> (w_rem < {1'b0, i_m}))
    `NRD_ASSERT_NEVER(a_dbz_flags_clear, i_clk, i_rst_n, r_valid && r_dbz && (r_qneg || r_rneg || (r_qmag != '0) || (r_rmag != '0)))
    `NRD_ASSERT(a_result_holds, i_clk, i_rst_n, (r_valid && !o_out.ready) |=> (r_valid && $stable(r_qmag) && $stable(r_rmag)))

endmodule

>>> design/nonrestoring_signed_divider_top.sv
// ----------------------------------------------------------------------------
// nonrestoring_signed_divider_top
// Signed divider with sign-magnitude results, built as a chain of
// non-restoring step cells followed by a correction and result stage.
// ----------------------------------------------------------------------------
//   channel  | direction | payload
//   ---------+-----------+---------------------------------------------------
//   i_in     | in        | dividend, divisor (16-bit two's complement)
//   o_out    | out       | quotient/remainder magnitudes, signs, divide_by_zero
//
// One transaction is accepted per cycle while i_in.ready is high; each passes
// through the step cells in the chain and then the correction stage.
// Every stage has its own valid bit, so bubbles close up and i_in.ready drops
// only when the whole chain is full and the result is not taken.
// Reset clears the valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
module nonrestoring_signed_divider_top #(
    parameter int unsigned WIDTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    nrd_in_if.sink    i_in,
    nrd_out_if.source o_out
);

    logic                w_valid [0:WIDTH];
    logic                w_ready [0:WIDTH];
    logic [WIDTH:0]      w_acc   [0:WIDTH];
    logic [WIDTH-1:0]    w_q     [0:WIDTH];
    logic [WIDTH-1:0]    w_m     [0:WIDTH];
    nrd_pkg::t_flags     w_flags [0:WIDTH];

    logic                w_dn;
    logic                w_vn;
    logic [nrd_pkg::FIELD_W:0] w_dmag_full;
    logic [nrd_pkg::FIELD_W:0] w_vmag_full;

    // Magnitudes are formed one bit wider so that the most negative value fits,
    // then sized to WIDTH bits. Negation is taken against 2^16 so that the
    // wide magnitude never carries a stray top bit.
    always_comb begin
        w_dn = i_in.dividend[nrd_pkg::FIELD_W-1];
        w_vn = i_in.divisor[nrd_pkg::FIELD_W-1];
        w_dmag_full = w_dn ? ({1'b1, {nrd_pkg::FIELD_W{1'b0}}} - {1'b0, i_in.dividend})
                           : {1'b0, i_in.dividend};
        w_vmag_full = w_vn ? ({1'b1, {nrd_pkg::FIELD_W{1'b0}}} - {1'b0, i_in.divisor})
                           : {1'b0, i_in.divisor};
    end

    assign w_valid[0]      = i_in.valid;
    assign i_in.ready      = w_ready[0];
    assign w_acc[0]        = '0;
    assign w_q[0]          = WIDTH'(w_dmag_full);
    assign w_m[0]          = WIDTH'(w_vmag_full);
    assign w_flags[0].qneg = (i_in.dividend != '0) && (i_in.divisor != '0) && (w_dn != w_vn);
    assign w_flags[0].rneg = w_dn;
    assign w_flags[0].dbz  = (WIDTH'(w_vmag_full) == '0);

    for (genvar g = 0; g < WIDTH; g++) begin : g_cell
        nrd_cell #(
            .WIDTH (WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_acc   (w_acc[g]),
            .i_q     (w_q[g]),
            .i_m     (w_m[g]),
            .i_flags (w_flags[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_acc   (w_acc[g+1]),
            .o_q     (w_q[g+1]),
            .o_m     (w_m[g+1]),
            .o_flags (w_flags[g+1])
        );
    end

    nrd_final #(
        .WIDTH (WIDTH)
    ) u_final (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[WIDTH]),
        .o_ready (w_ready[WIDTH]),
        .i_acc   (w_acc[WIDTH]),
        .i_q     (w_q[WIDTH]),
        .i_m     (w_m[WIDTH]),
        .i_flags (w_flags[WIDTH]),
        .o_out   (o_out)
    );

endmodule

>>> tb/tb_nonrestoring_signed_divider_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nonrestoring_signed_divider_top
// Self-checking bench for the signed non-restoring divider. A short table
// of directed operand pairs is followed by random pairs. Each expected
// result comes from its table row or from a bit-accurate model of the
// division steps, and each result out is compared field by field, in order.
// Both channels stall at random, and one long result hold-off fills the chain.
// ----------------------------------------------------------------------------
module tb_nonrestoring_signed_divider_top;

    localparam int unsigned DIV_WIDTH    = 16;
    localparam int unsigned RANDOM_ITEMS = 600;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DIRECTED_N   = 24;

    typedef struct packed {
        nrd_pkg::t_mag quotient_magnitude;
        logic          quotient_negative;
        nrd_pkg::t_mag remainder_magnitude;
        logic          remainder_negative;
        logic          divide_by_zero;
    } t_division_result;

    // A row either carries its answer (typed = 1) or leaves it to the model.
    typedef struct packed {
        nrd_pkg::t_operand dividend;
        nrd_pkg::t_operand divisor;
        logic              typed;
        nrd_pkg::t_mag     q_mag;
        logic              q_neg;
        nrd_pkg::t_mag     r_mag;
        logic              r_neg;
        logic              dbz;
    } t_division_row;

    logic i_clk;
    logic i_rst_n;

    nrd_in_if  in_ch ();
    nrd_out_if out_ch ();

    nonrestoring_signed_divider_top #(
        .WIDTH(DIV_WIDTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    t_division_result expected_results[$];
    int unsigned      mismatches   = 0;
    int unsigned      results_seen = 0;
    int unsigned      cycle_count  = 0;
    bit               feed_steady  = 1'b0;

    t_division_row directed_rows [DIRECTED_N] = '{
        '{16'sd100,   16'sd0,      1'b1, 16'd0,     1'b0, 16'd0,     1'b0, 1'b1},
        '{16'sh8000,  16'sd0,      1'b1, 16'd0,     1'b0, 16'd0,     1'b0, 1'b1},
        '{16'sd0,     16'sd0,      1'b1, 16'd0,     1'b0, 16'd0,     1'b0, 1'b1},
        '{16'sh7FFF,  16'sd0,      1'b1, 16'd0,     1'b0, 16'd0,     1'b0, 1'b1},
        '{16'sh8000,  16'sd1,      1'b1, 16'd32768, 1'b1, 16'd0,     1'b1, 1'b0},
        '{16'sh8000,  -16'sd1,     1'b1, 16'd32768, 1'b0, 16'd0,     1'b1, 1'b0},
        '{16'sh8000,  16'sh8000,   1'b1, 16'd1,     1'b0, 16'd0,     1'b1, 1'b0},
        '{16'sh7FFF,  16'sh8000,   1'b1, 16'd0,     1'b1, 16'd32767, 1'b0, 1'b0},
        '{16'sh7FFF,  16'sd1,      1'b1, 16'd32767, 1'b0, 16'd0,     1'b0, 1'b0},
        '{16'sh7FFF,  16'sh7FFF,   1'b1, 16'd1,     1'b0, 16'd0,     1'b0, 1'b0},
        '{16'sd0,     -16'sd5,     1'b1, 16'd0,     1'b0, 16'd0,     1'b0, 1'b0},
        '{16'sd7,     16'sd2,      1'b1, 16'd3,     1'b0, 16'd1,     1'b0, 1'b0},
        '{-16'sd7,    16'sd2,      1'b1, 16'd3,     1'b1, 16'd1,     1'b1, 1'b0},
        '{16'sd7,     -16'sd2,     1'b1, 16'd3,     1'b1, 16'd1,     1'b0, 1'b0},
        '{-16'sd7,    -16'sd2,     1'b1, 16'd3,     1'b0, 16'd1,     1'b1, 1'b0},
        '{-16'sd1,    16'sh7FFF,   1'b1, 16'd0,     1'b1, 16'd1,     1'b1, 1'b0},
        '{16'sh8000,  16'sh7FFF,   1'b1, 16'd1,     1'b1, 16'd1,     1'b1, 1'b0},
        '{-16'sd1,    16'sh8000,   1'b1, 16'd0,     1'b0, 16'd1,     1'b1, 1'b0},
        '{16'sd12345, -16'sd123,   1'b0, 16'd0,     1'b0, 16'd0,     1'b0, 1'b0},
        '{-16'sd30000, 16'sd7,     1'b0, 16'd0,     1'b0, 16'd0,     1'b0, 1'b0},
        '{16'sh5555,  16'sh2AAA,   1'b0, 16'd0,     1'b0, 16'd0,     1'b0, 1'b0},
        '{16'shAAAA,  -16'sd3,     1'b0, 16'd0,     1'b0, 16'd0,     1'b0, 1'b0},
        '{16'sd1,     16'sd2,      1'b0, 16'd0,     1'b0, 16'd0,     1'b0, 1'b0},
        '{16'sh7FFF,  16'sd2,      1'b0, 16'd0,     1'b0, 16'd0,     1'b0, 1'b0}
    };

    // Shift-and-add/subtract on a DIV_WIDTH+1 bit accumulator, one quotient
    // bit per step, then a single correction of a negative remainder.
    function automatic t_division_result divide_operands(
        input nrd_pkg::t_operand dividend,
        input nrd_pkg::t_operand divisor
    );
        logic                      dvd_neg;
        logic                      dvs_neg;
        logic [nrd_pkg::FIELD_W:0] dvd_full;
        logic [nrd_pkg::FIELD_W:0] dvs_full;
        logic [DIV_WIDTH-1:0]      dvd_mag;
        logic [DIV_WIDTH-1:0]      dvs_mag;
        logic [DIV_WIDTH-1:0]      quo;
        logic [DIV_WIDTH:0]        acc;
        logic                      acc_was_neg;
        t_division_result          res;

        res      = '0;
        dvd_neg  = dividend[nrd_pkg::FIELD_W-1];
        dvs_neg  = divisor[nrd_pkg::FIELD_W-1];
        dvd_full = dvd_neg ? (17'h10000 - {1'b0, dividend}) : {1'b0, dividend};
        dvs_full = dvs_neg ? (17'h10000 - {1'b0, divisor}) : {1'b0, divisor};
        dvd_mag  = DIV_WIDTH'(dvd_full);
        dvs_mag  = DIV_WIDTH'(dvs_full);

        if (dvs_mag == '0) begin
            res.divide_by_zero = 1'b1;
            return res;
        end

        acc = '0;
        quo = dvd_mag;
        for (int step = 0; step < DIV_WIDTH; step++) begin
            acc_was_neg = acc[DIV_WIDTH];
            acc         = {acc[DIV_WIDTH-1:0], quo[DIV_WIDTH-1]};
            quo         = quo << 1;
            acc         = acc_was_neg ? acc + dvs_mag : acc - dvs_mag;
            quo[0]      = ~acc[DIV_WIDTH];
        end
        if (acc[DIV_WIDTH]) begin
            acc = acc + dvs_mag;
        end

        res.quotient_magnitude  = nrd_pkg::FIELD_W'(quo);
        res.remainder_magnitude = nrd_pkg::FIELD_W'(acc);
        res.quotient_negative   = (dividend != '0) && (divisor != '0) && (dvd_neg != dvs_neg);
        res.remainder_negative  = dvd_neg;
        return res;
    endfunction

    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            mismatches++;
        end
    endtask

    // Drives one operand pair from a falling edge and returns at the falling
    // edge after the transaction has been accepted.
    task automatic offer_operands(input nrd_pkg::t_operand dividend,
                                  input nrd_pkg::t_operand divisor,
                                  input t_division_result want);
        while (!feed_steady && $urandom_range(99) < 31) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.dividend <= dividend;
        in_ch.divisor  <= divisor;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        expected_results.push_back(want);
        @(negedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever begin
            #1 i_clk = ~i_clk;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_division_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $error("result transaction arrived with nothing outstanding");
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                compare_field("quotient_magnitude", want.quotient_magnitude,
                              out_ch.quotient_magnitude);
                compare_field("quotient_negative", want.quotient_negative,
                              out_ch.quotient_negative);
                compare_field("remainder_magnitude", want.remainder_magnitude,
                              out_ch.remainder_magnitude);
                compare_field("remainder_negative", want.remainder_negative,
                              out_ch.remainder_negative);
                compare_field("divide_by_zero", want.divide_by_zero,
                              out_ch.divide_by_zero);
            end
        end
    end

    // Result side: one long hold-off early in the steady stretch of the
    // sender so the chain fills, a stall-free window later, random otherwise.
    initial begin : result_drain
        int unsigned hold_left;
        bit          hold_done;
        hold_left    = 0;
        hold_done    = 1'b0;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!hold_done && results_seen >= 60) begin
                hold_done = 1'b1;
                hold_left = 120;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (results_seen >= 300 && results_seen < 450) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= 31);
            end
        end
    end

    initial begin : operand_feed
        nrd_pkg::t_operand dividend;
        nrd_pkg::t_operand divisor;
        t_division_result  want;
        int unsigned       item_no;

        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.dividend  = '0;
        in_ch.divisor   = '0;
        item_no         = 0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[row]) begin
            if (directed_rows[row].typed) begin
                want.quotient_magnitude  = directed_rows[row].q_mag;
                want.quotient_negative   = directed_rows[row].q_neg;
                want.remainder_magnitude = directed_rows[row].r_mag;
                want.remainder_negative  = directed_rows[row].r_neg;
                want.divide_by_zero      = directed_rows[row].dbz;
            end else begin
                want = divide_operands(directed_rows[row].dividend,
                                       directed_rows[row].divisor);
            end
            offer_operands(directed_rows[row].dividend, directed_rows[row].divisor, want);
            item_no++;
        end

        for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
            feed_steady = (item_no >= 40 && item_no < 300);
            dividend    = nrd_pkg::t_operand'($urandom());
            divisor     = nrd_pkg::t_operand'($urandom());
            case ($urandom_range(9))
                4, 5: divisor = nrd_pkg::t_operand'(int'($urandom_range(40)) - 20);
                6: divisor = '0;
                7: begin
                    case ($urandom_range(3))
                        0: dividend = 16'sh8000;
                        1: dividend = 16'sh7FFF;
                        2: dividend = '0;
                        default: dividend = -16'sd1;
                    endcase
                end
                8: divisor = nrd_pkg::t_operand'(int'(dividend) + int'($urandom_range(4)) - 2);
                9: begin
                    case ($urandom_range(3))
                        0: divisor = 16'sh8000;
                        1: divisor = 16'sh7FFF;
                        2: divisor = 16'sd1;
                        default: divisor = -16'sd1;
                    endcase
                end
                default: ;
            endcase
            offer_operands(dividend, divisor, divide_operands(dividend, divisor));
            item_no++;
        end

        feed_steady = 1'b0;
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DIV_WIDTH + 8) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/nrd_pkg.sv
design/nrd_in_if.sv
design/nrd_out_if.sv
design/nrd_cell.sv
design/nrd_final.sv
design/nonrestoring_signed_divider_top.sv
tb/tb_nonrestoring_signed_divider_top.sv
